### rtl/u8sv_pkg.sv
// package: item types and byte-class constants for the utf-8 stream validator
`default_nettype none

package u8sv_pkg;

    // width of an assembled code point
    localparam int unsigned CpWidth = 21;

    typedef logic [7:0]         t_byte;
    typedef logic [CpWidth-1:0] t_code_point;
    typedef logic [1:0]         t_count;

    // control bytes rejected anywhere in a string
    localparam t_byte ByteNul = 8'h00;
    localparam t_byte ByteLf  = 8'h0a;
    localparam t_byte ByteCr  = 8'h0d;

    // lead and continuation byte classes
    localparam t_byte AsciiLimit   = 8'h80;
    localparam t_byte Lead2Mask    = 8'he0;
    localparam t_byte Lead2Code    = 8'hc0;
    localparam t_byte Lead2Min     = 8'hc2;
    localparam t_byte Lead3Mask    = 8'hf0;
    localparam t_byte Lead3Code    = 8'he0;
    localparam t_byte Lead4Mask    = 8'hf8;
    localparam t_byte Lead4Code    = 8'hf0;
    localparam t_byte Lead4Max     = 8'hf4;
    localparam t_byte ContTagMask  = 8'hc0;
    localparam t_byte ContTagCode  = 8'h80;
    localparam t_byte ContDataMask = 8'h3f;

    // code point limits
    localparam t_code_point Min3Byte  = 21'h000800;
    localparam t_code_point Min4Byte  = 21'h010000;
    localparam t_code_point SurrLow   = 21'h00d800;
    localparam t_code_point SurrHigh  = 21'h00dfff;
    localparam t_code_point MaxCp     = 21'h10ffff;

    // continuation counts of an open sequence
    localparam t_count SeqNone  = 2'd0;
    localparam t_count SeqTwo   = 2'd1;
    localparam t_count SeqThree = 2'd2;
    localparam t_count SeqFour  = 2'd3;

endpackage

`default_nettype wire

### rtl/u8sv_byte_if.sv
// interface: input channel carrying one string byte per item
`default_nettype none

interface u8sv_byte_if;
    logic             valid;
    logic             ready;
    u8sv_pkg::t_byte  data_byte;
    logic             last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

### rtl/u8sv_verdict_if.sv
// interface: output channel carrying the running verdict per item
`default_nettype none

interface u8sv_verdict_if;
    logic valid;
    logic ready;
    logic string_ok;
    logic end_of_string;

    modport source (output valid, output string_ok, output end_of_string, input ready);
    modport sink   (input valid, input string_ok, input end_of_string, output ready);
endinterface

`default_nettype wire

### rtl/utf8_stream_validator_unit.sv
// top level: streaming strict utf-8 validator, one byte per clock while not stalled
//
// usage
// - i_byte_ch takes one byte of a string per item, with last set on the final byte
// - o_verdict_ch gives one item per byte: string_ok is the running verdict and
//   end_of_string echoes last; on the last byte string_ok is the final verdict
// - rejects nul, lf, cr, bad or missing continuation bytes, leads c0, c1, f5..ff,
//   overlong 3- and 4-byte forms, surrogates and code points above 10ffff
// - an empty string never reaches the block; the host treats it as valid
// timing
// - path: input register, then per-byte state update, then verdict register
// - throughput: one item per cycle while the receiver holds ready high; the only loop
//   is the per-byte state update, which fits between the input and verdict registers
// - stall: when the receiver holds ready low the verdict register holds, the
//   input register keeps one more byte, then i_byte_ch.ready drops
// reset
// - synchronous active-low reset empties both registers and clears the string state
`default_nettype none

module utf8_stream_validator_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    u8sv_byte_if.sink           i_byte_ch,
    u8sv_verdict_if.source      o_verdict_ch
);

    // input register stage
    logic                  r_in_valid;
    u8sv_pkg::t_byte       r_in_byte;
    logic                  r_in_last;

    // string state
    logic                  r_error_seen,     n_error_seen;
    u8sv_pkg::t_count      r_bytes_pending,  n_bytes_pending;
    u8sv_pkg::t_count      r_seq_length,     n_seq_length;
    u8sv_pkg::t_code_point r_partial_cp,     n_partial_cp;

    // verdict register stage
    logic                  r_out_valid;
    logic                  r_out_ok,         n_out_ok;
    logic                  r_out_last;

    logic                  w_in_take;
    logic                  w_advance;
    u8sv_pkg::t_code_point w_cont_cp;

    // the byte in the input register moves on whenever the verdict slot is free
    assign w_advance        = r_in_valid && (!r_out_valid || o_verdict_ch.ready);
    assign i_byte_ch.ready  = !r_in_valid || w_advance;
    assign w_in_take        = i_byte_ch.valid && i_byte_ch.ready;

    // code point with this byte's six payload bits shifted in
    assign w_cont_cp = {r_partial_cp[u8sv_pkg::CpWidth-7:0],
                        r_in_byte[5:0] & u8sv_pkg::ContDataMask[5:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte_ch.ready) begin
            r_in_valid <= i_byte_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_byte_ch.data_byte;
            r_in_last <= i_byte_ch.last;
        end
    end

    // per-byte state update
    always_comb begin
        n_error_seen    = r_error_seen;
        n_bytes_pending = r_bytes_pending;
        n_seq_length    = r_seq_length;
        n_partial_cp    = r_partial_cp;

        if (!r_error_seen) begin
            if (r_bytes_pending == u8sv_pkg::SeqNone) begin
                // lead byte
                if (r_in_byte == u8sv_pkg::ByteNul || r_in_byte == u8sv_pkg::ByteLf ||
                    r_in_byte == u8sv_pkg::ByteCr) begin
                    n_error_seen = 1'b1;
                end else if (r_in_byte < u8sv_pkg::AsciiLimit) begin
                    // plain ascii, nothing to track
                end else if ((r_in_byte & u8sv_pkg::Lead2Mask) == u8sv_pkg::Lead2Code) begin
                    if (r_in_byte < u8sv_pkg::Lead2Min) begin
                        n_error_seen = 1'b1;
                    end else begin
                        n_bytes_pending = u8sv_pkg::SeqTwo;
                        n_seq_length    = u8sv_pkg::SeqTwo;
                        n_partial_cp    = u8sv_pkg::t_code_point'(r_in_byte[4:0]);
                    end
                end else if ((r_in_byte & u8sv_pkg::Lead3Mask) == u8sv_pkg::Lead3Code) begin
                    n_bytes_pending = u8sv_pkg::SeqThree;
                    n_seq_length    = u8sv_pkg::SeqThree;
                    n_partial_cp    = u8sv_pkg::t_code_point'(r_in_byte[3:0]);
                end else if ((r_in_byte & u8sv_pkg::Lead4Mask) == u8sv_pkg::Lead4Code) begin
                    if (r_in_byte > u8sv_pkg::Lead4Max) begin
                        n_error_seen = 1'b1;
                    end else begin
                        n_bytes_pending = u8sv_pkg::SeqFour;
                        n_seq_length    = u8sv_pkg::SeqFour;
                        n_partial_cp    = u8sv_pkg::t_code_point'(r_in_byte[2:0]);
                    end
                end else begin
                    // stray continuation or f8..ff
                    n_error_seen = 1'b1;
                end
            end else begin
                // continuation byte
                if ((r_in_byte & u8sv_pkg::ContTagMask) != u8sv_pkg::ContTagCode) begin
                    n_error_seen = 1'b1;
                end else begin
                    n_partial_cp    = w_cont_cp;
                    n_bytes_pending = r_bytes_pending - 2'd1;
                    if (r_bytes_pending == u8sv_pkg::SeqTwo) begin
                        // sequence complete: reject overlong, surrogate, out of range
                        if ((r_seq_length == u8sv_pkg::SeqThree &&
                             w_cont_cp < u8sv_pkg::Min3Byte) ||
                            (r_seq_length == u8sv_pkg::SeqFour &&
                             w_cont_cp < u8sv_pkg::Min4Byte) ||
                            (w_cont_cp >= u8sv_pkg::SurrLow &&
                             w_cont_cp <= u8sv_pkg::SurrHigh) ||
                            w_cont_cp > u8sv_pkg::MaxCp) begin
                            n_error_seen = 1'b1;
                        end else begin
                            n_seq_length = u8sv_pkg::SeqNone;
                            n_partial_cp = '0;
                        end
                    end
                end
            end

            // raising the error drops any open sequence
            if (n_error_seen) begin
                n_bytes_pending = u8sv_pkg::SeqNone;
                n_seq_length    = u8sv_pkg::SeqNone;
                n_partial_cp    = '0;
            end
        end

        n_out_ok = !n_error_seen && (n_bytes_pending == u8sv_pkg::SeqNone);

        // last byte closes the string, next item starts fresh
        if (r_in_last) begin
            n_error_seen    = 1'b0;
            n_bytes_pending = u8sv_pkg::SeqNone;
            n_seq_length    = u8sv_pkg::SeqNone;
            n_partial_cp    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_seen    <= 1'b0;
            r_bytes_pending <= u8sv_pkg::SeqNone;
            r_seq_length    <= u8sv_pkg::SeqNone;
            r_partial_cp    <= '0;
        end else if (w_advance) begin
            r_error_seen    <= n_error_seen;
            r_bytes_pending <= n_bytes_pending;
            r_seq_length    <= n_seq_length;
            r_partial_cp    <= n_partial_cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_ok   <= n_out_ok;
            r_out_last <= r_in_last;
        end
    end

    assign o_verdict_ch.valid         = r_out_valid;
    assign o_verdict_ch.string_ok     = r_out_ok;
    assign o_verdict_ch.end_of_string = r_out_last;

`ifndef SYNTH
    // an error always drops the open sequence
    a_err_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error_seen |-> (r_bytes_pending == u8sv_pkg::SeqNone))
        else $error("pending continuation bytes while error flag is set");

    // pending count never exceeds the length of the open sequence
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_pending <= r_seq_length)
        else $error("pending count above sequence length");

    // a processed last byte leaves clean string state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last) |=>
            (!r_error_seen && r_bytes_pending == u8sv_pkg::SeqNone &&
             r_seq_length == u8sv_pkg::SeqNone && r_partial_cp == '0))
        else $error("string state not cleared after last byte");

    // a verdict taken into the output register reflects the state it leaves behind
    a_ok_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !r_in_last) |=>
            (r_out_ok == (!r_error_seen && r_bytes_pending == u8sv_pkg::SeqNone)))
        else $error("verdict disagrees with string state");
`endif

endmodule

`default_nettype wire

### verif/tb.sv
// testbench: strict utf-8 stream validator, checked byte by byte against a local predictor
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one verdict item as the block should emit it
    typedef struct packed {
        logic ok;
        logic eos;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8sv_byte_if    byte_ch ();
    u8sv_verdict_if verdict_ch ();

    utf8_stream_validator_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_ch    (byte_ch),
        .o_verdict_ch (verdict_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // verdicts owed by the block, oldest first
    t_verdict    verdicts_due[$];
    int unsigned fail_count = 0;

    // bytes handed to the block so far
    int unsigned sent_bytes = 0;

    // idle control: steady is shared by both sides, hold_req drives the receiver only
    logic        steady   = 1'b0;  // no gaps and no stalls while set
    int unsigned hold_req = 0;     // long receiver hold-off, in cycles

    // predictor state for the current string
    logic                  str_bad;
    u8sv_pkg::t_count      cont_left;
    u8sv_pkg::t_count      seq_kind;
    u8sv_pkg::t_code_point cp_acc;

    function automatic void clear_string();
        str_bad   = 1'b0;
        cont_left = '0;
        seq_kind  = u8sv_pkg::SeqNone;
        cp_acc    = '0;
    endfunction

    // an error drops any open sequence, and the flag sticks until the last byte
    function automatic void mark_bad();
        clear_string();
        str_bad = 1'b1;
    endfunction

    function automatic void open_seq(input u8sv_pkg::t_count kind,
                                     input u8sv_pkg::t_code_point bits);
        cont_left = kind;
        seq_kind  = kind;
        cp_acc    = bits;
    endfunction

    // advance the string state by one byte and give the verdict it yields
    function automatic t_verdict judge_byte(input u8sv_pkg::t_byte b, input logic lst);
        u8sv_pkg::t_code_point nxt;
        t_verdict              v;
        if (!str_bad && cont_left == 0) begin
            // lead position
            if (b == u8sv_pkg::ByteNul || b == u8sv_pkg::ByteLf ||
                b == u8sv_pkg::ByteCr) begin
                mark_bad();
            end else if (b >= u8sv_pkg::AsciiLimit) begin
                if ((b & u8sv_pkg::Lead2Mask) == u8sv_pkg::Lead2Code) begin
                    if (b < u8sv_pkg::Lead2Min) begin
                        mark_bad();
                    end else begin
                        open_seq(u8sv_pkg::SeqTwo, u8sv_pkg::t_code_point'(b[4:0]));
                    end
                end else if ((b & u8sv_pkg::Lead3Mask) == u8sv_pkg::Lead3Code) begin
                    open_seq(u8sv_pkg::SeqThree, u8sv_pkg::t_code_point'(b[3:0]));
                end else if ((b & u8sv_pkg::Lead4Mask) == u8sv_pkg::Lead4Code &&
                             b <= u8sv_pkg::Lead4Max) begin
                    open_seq(u8sv_pkg::SeqFour, u8sv_pkg::t_code_point'(b[2:0]));
                end else begin
                    mark_bad();
                end
            end
        end else if (!str_bad) begin
            // continuation position: no resync on a foreign byte
            if ((b & u8sv_pkg::ContTagMask) != u8sv_pkg::ContTagCode) begin
                mark_bad();
            end else begin
                nxt       = {cp_acc[u8sv_pkg::CpWidth-7:0], b[5:0]};
                cp_acc    = nxt;
                cont_left = cont_left - 1'b1;
                if (cont_left == 0) begin
                    if ((seq_kind == u8sv_pkg::SeqThree && nxt < u8sv_pkg::Min3Byte) ||
                        (seq_kind == u8sv_pkg::SeqFour && nxt < u8sv_pkg::Min4Byte) ||
                        (nxt >= u8sv_pkg::SurrLow && nxt <= u8sv_pkg::SurrHigh) ||
                        nxt > u8sv_pkg::MaxCp) begin
                        mark_bad();
                    end else begin
                        seq_kind = u8sv_pkg::SeqNone;
                        cp_acc   = '0;
                    end
                end
            end
        end
        v.ok  = !str_bad && cont_left == 0;
        v.eos = lst;
        if (lst) begin
            clear_string();
        end
        return v;
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (steady || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    // receiver stall length once it decides to stall
    function automatic int unsigned pick_stall();
        if ($urandom_range(99) < 85) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(25, 8);
    endfunction

    // offer one byte at a falling edge and hold it until taken
    task automatic send_byte(input u8sv_pkg::t_byte b, input logic lst);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            byte_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid     = 1'b1;
        byte_ch.data_byte = b;
        byte_ch.last      = lst;
        do @(posedge i_clk); while (!byte_ch.ready);
        sent_bytes++;
        verdicts_due.push_back(judge_byte(b, lst));
        @(negedge i_clk);
    endtask

    task automatic send_string(input u8sv_pkg::t_byte s[$]);
        foreach (s[i]) begin
            send_byte(s[i], i == s.size() - 1);
        end
    endtask

    // append one well-formed character of a random length class
    function automatic void add_char(ref u8sv_pkg::t_byte s[$]);
        int unsigned cp;
        case ($urandom_range(3))
            0: begin
                do cp = $urandom_range(127, 1);
                while (cp == u8sv_pkg::ByteLf || cp == u8sv_pkg::ByteCr);
                s.push_back(u8sv_pkg::t_byte'(cp));
            end
            1: begin
                cp = $urandom_range(32'h7ff, 32'h80);
                s.push_back({3'b110, cp[10:6]});
                s.push_back({2'b10, cp[5:0]});
            end
            2: begin
                do cp = $urandom_range(32'hffff, 32'h800);
                while (cp >= u8sv_pkg::SurrLow && cp <= u8sv_pkg::SurrHigh);
                s.push_back({4'b1110, cp[15:12]});
                s.push_back({2'b10, cp[11:6]});
                s.push_back({2'b10, cp[5:0]});
            end
            default: begin
                cp = $urandom_range(32'h10ffff, 32'h10000);
                s.push_back({5'b11110, cp[20:18]});
                s.push_back({2'b10, cp[17:12]});
                s.push_back({2'b10, cp[11:6]});
                s.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // smallest 2- and 3-byte forms and the largest 4-byte form in one good string
    task automatic test_valid_boundaries();
        send_string({8'hc2, 8'h80, 8'he0, 8'ha0, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf});
    endtask

    // nul, lf and cr as a lead byte
    task automatic test_control_bytes();
        send_string({u8sv_pkg::ByteNul});
        send_string({u8sv_pkg::ByteLf});
        send_string({u8sv_pkg::ByteCr});
    endtask

    task automatic test_bad_leads();
        // c1 is always overlong, the ascii byte after it falls under the sticky error
        send_string({8'hc1, 8'h41});
        send_string({8'hf5});
        // continuation with no lead
        send_string({8'h80});
    endtask

    task automatic test_range_errors();
        send_string({8'he0, 8'h9f, 8'hbf});           // overlong 3-byte
        send_string({8'hf0, 8'h8f, 8'hbf, 8'hbf});    // overlong 4-byte
        send_string({8'hed, 8'ha0, 8'h80});           // first surrogate
        send_string({8'hf4, 8'h90, 8'h80, 8'h80});    // just above the last code point
    endtask

    task automatic test_truncation();
        // sequence still open at the last byte
        send_string({8'hc3});
        // cr where a continuation is due: no resync, string fails
        send_string({8'hc3, u8sv_pkg::ByteCr});
    endtask

    // receiver holds off while a gapless string keeps coming, so the input stalls
    task automatic test_output_backpressure();
        u8sv_pkg::t_byte s[$];
        s = {};
        while (s.size() < 24) begin
            add_char(s);
        end
        hold_req = 60;
        steady   = 1'b1;
        send_string(s);
        steady   = 1'b0;
    endtask

    // mostly well-formed strings with random content, the rest noise and broken ones
    task automatic test_random_strings();
        u8sv_pkg::t_byte s[$];
        int unsigned     n;
        int unsigned     pos;
        int unsigned     kind;
        int unsigned     target;
        target = sent_bytes + 340;
        while (sent_bytes < target) begin
            s      = {};
            steady = ($urandom_range(9) == 0);
            kind   = $urandom_range(99);
            if (kind < 12) begin
                n = $urandom_range(6, 1);
                repeat (n) s.push_back(u8sv_pkg::t_byte'($urandom_range(255)));
            end else begin
                n = $urandom_range(8, 1);
                repeat (n) add_char(s);
                if (kind < 20) begin
                    // one byte replaced by anything
                    pos    = $urandom_range(s.size() - 1);
                    s[pos] = u8sv_pkg::t_byte'($urandom_range(255));
                end else if (kind < 26 && s.size() > 1) begin
                    // cut short, possibly in the middle of a sequence
                    void'(s.pop_back());
                end
            end
            send_string(s);
        end
        steady = 1'b0;
    endtask

    // receiver: random stalls, plus the long hold-off on request
    initial begin : verdict_sink
        int unsigned wait_left;
        wait_left        = 0;
        verdict_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                wait_left = hold_req;
                hold_req  = 0;
            end
            if (wait_left != 0) begin
                verdict_ch.ready = 1'b0;
                wait_left--;
            end else if (steady || $urandom_range(99) < 70) begin
                verdict_ch.ready = 1'b1;
            end else begin
                verdict_ch.ready = 1'b0;
                wait_left        = pick_stall() - 1;
            end
        end
    end

    // every verdict item goes against the oldest one owed
    always @(posedge i_clk) begin : check_verdicts
        t_verdict want;
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict item with none expected: ok=%0b eos=%0b",
                         $time, verdict_ch.string_ok, verdict_ch.end_of_string);
                fail_count++;
            end else begin
                want = verdicts_due.pop_front();
                if (verdict_ch.string_ok !== want.ok) begin
                    $display("%0t: string_ok expected %0b, got %0b",
                             $time, want.ok, verdict_ch.string_ok);
                    fail_count++;
                end
                if (verdict_ch.end_of_string !== want.eos) begin
                    $display("%0t: end_of_string expected %0b, got %0b",
                             $time, want.eos, verdict_ch.end_of_string);
                    fail_count++;
                end
            end
        end
    end

    initial begin : run_tests
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last      = 1'b0;
        clear_string();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_valid_boundaries();
        test_control_bytes();
        test_bad_leads();
        test_range_errors();
        test_truncation();
        test_output_backpressure();
        test_random_strings();

        byte_ch.valid = 1'b0;
        while (verdicts_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // guard against a hung handshake, far above the slowest correct run
    initial begin : watchdog
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
